FILE: src/argument_tokenizer_unit_defines.svh
// -----------------------------------------------------------------------------
// argument_tokenizer_unit_defines.svh
// Assertion macros used by the checker file.
// -----------------------------------------------------------------------------
`ifndef ARGUMENT_TOKENIZER_UNIT_DEFINES_SVH
`define ARGUMENT_TOKENIZER_UNIT_DEFINES_SVH

// Implication checked on every rising edge of clk, off during reset.
`define ATU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, also active while reset is high.
`define ATU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/argtok_pkg.sv
// -----------------------------------------------------------------------------
// argtok_pkg
// Shared types and constants of the argument tokenizer.
// -----------------------------------------------------------------------------
package argtok_pkg;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;

  // Depth of the command queue between front and back.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_LIST_END  = 2'd2
  } kind_t;

  // Results caused by one input: slot A from the byte itself, slot B a
  // closing token end at the final item, slot C the end-of-list mark.
  typedef struct packed {
    logic       has_a;
    kind_t      a_kind;
    logic [7:0] a_byte;
    logic       has_b;
    logic       has_c;
  } cmd_t;

endpackage

FILE: src/argtok_front.sv
// -----------------------------------------------------------------------------
// argtok_front
// Accepts input bytes, tracks quote/escape/token state, emits commands.
// -----------------------------------------------------------------------------
module argtok_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        ch,
  input  logic              has_char,
  input  logic              last,
  input  logic              push,
  output logic              full,
  input  logic              q_full,
  output logic              q_push,
  output argtok_pkg::cmd_t  q_cmd
);
  import argtok_pkg::*;

  logic in_quote, escape_pending, token_open;
  logic in_quote_next, escape_pending_next, token_open_next;
  logic tok_after, accept;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {[8'h09:8'h0D], 8'h20, 8'h85, 8'hA0};
  endfunction

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    q_cmd               = '0;
    q_cmd.a_kind        = KIND_BYTE;
    in_quote_next       = in_quote;
    escape_pending_next = escape_pending;
    tok_after           = token_open;
    if (has_char) begin
      if (escape_pending) begin
        q_cmd.has_a         = 1'b1;
        q_cmd.a_byte        = ch;
        tok_after           = 1'b1;
        escape_pending_next = 1'b0;
      end else if (ch == CH_BACKSLASH) begin
        escape_pending_next = 1'b1;
      end else if (in_quote) begin
        q_cmd.has_a = 1'b1;
        if (ch == CH_QUOTE) begin
          q_cmd.a_kind  = KIND_TOKEN_END;
          tok_after     = 1'b0;
          in_quote_next = 1'b0;
        end else begin
          q_cmd.a_byte = ch;
          tok_after    = 1'b1;
        end
      end else if (ch == CH_QUOTE) begin
        if (token_open) begin
          q_cmd.has_a  = 1'b1;
          q_cmd.a_byte = ch;
        end else begin
          in_quote_next = 1'b1;
        end
      end else if (is_space(ch)) begin
        if (token_open) begin
          q_cmd.has_a  = 1'b1;
          q_cmd.a_kind = KIND_TOKEN_END;
          tok_after    = 1'b0;
        end
      end else begin
        q_cmd.has_a  = 1'b1;
        q_cmd.a_byte = ch;
        tok_after    = 1'b1;
      end
    end
    token_open_next = tok_after;
    if (last) begin
      q_cmd.has_b         = tok_after;
      q_cmd.has_c         = 1'b1;
      in_quote_next       = 1'b0;
      escape_pending_next = 1'b0;
      token_open_next     = 1'b0;
    end
  end

  // Items that cause no result take no queue entry.
  assign q_push = accept && (q_cmd.has_a || q_cmd.has_b || q_cmd.has_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quote       <= 1'b0;
      escape_pending <= 1'b0;
      token_open     <= 1'b0;
    end else if (accept) begin
      in_quote       <= in_quote_next;
      escape_pending <= escape_pending_next;
      token_open     <= token_open_next;
    end
  end

endmodule

FILE: src/argtok_fifo.sv
// -----------------------------------------------------------------------------
// argtok_fifo
// Short command queue between front and back.
// -----------------------------------------------------------------------------
module argtok_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  argtok_pkg::cmd_t  wr_cmd,
  output logic              q_full,
  input  logic              rd_en,
  output logic              q_empty,
  output argtok_pkg::cmd_t  rd_cmd
);
  import argtok_pkg::*;

  cmd_t              entries [QDepth];
  logic [QPtrW-1:0]  wr_ptr, rd_ptr;
  logic [QPtrW:0]    count;
  logic              do_wr, do_rd;

  assign q_full  = (count == (QPtrW+1)'(QDepth));
  assign q_empty = (count == '0);
  assign rd_cmd  = entries[rd_ptr];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/argtok_back.sv
// -----------------------------------------------------------------------------
// argtok_back
// Expands queued commands into result requests, one per cycle while the output is free or popped.
// -----------------------------------------------------------------------------
module argtok_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  argtok_pkg::cmd_t  head,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        kind,
  output logic [7:0]        byte_out,
  output logic              run_last
);
  import argtok_pkg::*;

  logic [2:0] done, done_next;
  logic [2:0] remaining, pick, rest;
  logic       out_valid, out_last;
  kind_t      out_kind;
  logic [7:0] out_byte;
  kind_t      sel_kind;
  logic [7:0] sel_byte;
  logic       issue;

  assign remaining = {head.has_c, head.has_b, head.has_a} & ~done;
  // Lowest pending slot goes first.
  assign pick  = remaining & (~remaining + 3'd1);
  assign rest  = remaining & ~pick;
  assign issue = !q_empty && (!out_valid || pop);
  assign q_pop = issue && (rest == '0);

  always_comb begin
    sel_kind = KIND_LIST_END;
    sel_byte = '0;
    if (pick[0]) begin
      sel_kind = head.a_kind;
      sel_byte = head.a_byte;
    end else if (pick[1]) begin
      sel_kind = KIND_TOKEN_END;
    end
  end

  always_comb begin
    done_next = done;
    if (issue) begin
      done_next = (rest == '0) ? 3'b000 : (done | pick);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else begin
      done <= done_next;
      if (issue) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_kind <= sel_kind;
      out_byte <= sel_byte;
      out_last <= (rest == '0);
    end
  end

  assign empty    = !out_valid;
  assign kind     = out_kind;
  assign byte_out = out_byte;
  assign run_last = out_last;

endmodule

FILE: src/argument_tokenizer_unit.sv
// -----------------------------------------------------------------------------
// argument_tokenizer_unit
// Splits a Latin-1 byte stream into command-line arguments.
// -----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive ch/has_char/last and raise push; a request is
//   taken on a clock edge with push high and full low. One byte per request;
//   last marks the final request of an argument string (has_char may be 0
//   there for an empty final request).
//   Result queue side: while empty is low, kind/byte_out/run_last show the
//   oldest result; it is taken on an edge with pop high. kind is token byte,
//   token end or end of list; run_last flags the final result of a request.
// Timing:
//   The front decodes a request in its accept cycle and writes a command
//   into a 4-entry queue; the back turns it into results, one per cycle while
//   the receiver pops, into the output register. The first result passes the
//   queue entry, then the output register, before it is on the ports.
//   A request with one result sustains one request per cycle while the
//   receiver pops; a request with several results holds the output longer,
//   which the queue absorbs. Requests that cause no result use no queue entry.
// Reset: rst (synchronous) clears the tokenizer state, the queue and the
//   output register. A stalled receiver fills the queue, then full rises.
// -----------------------------------------------------------------------------
module argument_tokenizer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] ch,
  input  logic       has_char,
  input  logic       last,
  input  logic       push,
  output logic       full,
  output logic [1:0] kind,
  output logic [7:0] byte_out,
  output logic       run_last,
  output logic       empty,
  input  logic       pop
);
  import argtok_pkg::*;

  cmd_t q_cmd, head;
  logic q_push, q_full, q_empty, q_pop;

  // Front: classify each byte and update quote/escape/token flags.
  argtok_front u_front (
    .clk      (clk),
    .rst      (rst),
    .ch       (ch),
    .has_char (has_char),
    .last     (last),
    .push     (push),
    .full     (full),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // Decoupling queue of result commands.
  argtok_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_cmd  (q_cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_empty (q_empty),
    .rd_cmd  (head)
  );

  // Back: emit up to three results per command through the output register.
  argtok_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .kind     (kind),
    .byte_out (byte_out),
    .run_last (run_last)
  );

endmodule

FILE: src/argtok_checker.sv
// -----------------------------------------------------------------------------
// argtok_checker
// Port-level checks of the argument tokenizer, bound to the top level.
// -----------------------------------------------------------------------------
`include "argument_tokenizer_unit_defines.svh"

module argtok_checker (
  input logic       clk,
  input logic       rst,
  input logic [7:0] ch,
  input logic       has_char,
  input logic       last,
  input logic       push,
  input logic       full,
  input logic [1:0] kind,
  input logic [7:0] byte_out,
  input logic       run_last,
  input logic       empty,
  input logic       pop
);
  import argtok_pkg::*;

  `ATU_ASSERT(a_hold_stalled, !empty && !pop |=> !empty && $stable(kind) && $stable(byte_out) && $stable(run_last), "result changed while stalled")
  `ATU_ASSERT(a_kind_legal, !empty |-> kind == KIND_BYTE || kind == KIND_TOKEN_END || kind == KIND_LIST_END, "illegal result kind")
  `ATU_ASSERT(a_byte_zero, !empty && kind != KIND_BYTE |-> byte_out == 8'h00, "marker carries nonzero byte")
  `ATU_ASSERT(a_list_end_last, !empty && kind == KIND_LIST_END |-> run_last, "end of list not final result")
  `ATU_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> empty, "results present after reset")

endmodule

bind argument_tokenizer_unit argtok_checker u_argtok_checker (.*);
